### rtl/core/pff_pkg.sv
// Shared package of the Pareto front filter: commands, result kinds,
// default sizes and the dominance verdict type. No dependencies.
`default_nettype none
package pff_pkg;

    localparam int CAPACITY_DEF       = 32;
    localparam int MAX_OBJECTIVES_DEF = 4;
    localparam int OBJ_WIDTH_DEF      = 16;

    localparam int ID_W   = 16;
    localparam int VIOL_W = 16;
    localparam int NOBJ_W = 3;

    localparam logic [NOBJ_W-1:0] NOBJ_RESET = 3'd2;

    localparam logic [1:0] CMD_SUBMIT = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_DRAIN  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] KIND_EVICT  = 3'd0;
    localparam logic [2:0] KIND_ACCEPT = 3'd1;
    localparam logic [2:0] KIND_REJECT = 3'd2;
    localparam logic [2:0] KIND_FULL   = 3'd3;
    localparam logic [2:0] KIND_DRAIN  = 3'd4;
    localparam logic [2:0] KIND_CLEAR  = 3'd5;
    localparam logic [2:0] KIND_EMPTY  = 3'd6;

    // Verdict of the comparator: the candidate wins, or the stored entry wins.
    typedef struct packed {
        logic cand_wins;
        logic entry_wins;
    } dom_t;

endpackage
`default_nettype wire

### rtl/core/pff_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pff_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/core/pff_dom.sv
// Constrained dominance comparator between the candidate and one stored entry.
// Depends on pff_pkg.
`default_nettype none
module pff_dom #(
    parameter int MAX_OBJECTIVES = pff_pkg::MAX_OBJECTIVES_DEF,
    parameter int OBJ_WIDTH      = pff_pkg::OBJ_WIDTH_DEF
) (
    input  wire logic [MAX_OBJECTIVES*OBJ_WIDTH-1:0] cand_obj,
    input  wire logic [pff_pkg::VIOL_W-1:0]          cand_viol,
    input  wire logic [MAX_OBJECTIVES*OBJ_WIDTH-1:0] entry_obj,
    input  wire logic [pff_pkg::VIOL_W-1:0]          entry_viol,
    input  wire logic [pff_pkg::NOBJ_W-1:0]          num_obj,
    output pff_pkg::dom_t                            verdict
);

    logic [pff_pkg::NOBJ_W-1:0] n_eff;
    logic better;
    logic worse;
    logic cand_inf;
    logic entry_inf;

    always_comb
    begin
        if (num_obj == '0)
        begin
            n_eff = pff_pkg::NOBJ_W'(1);
        end
        else if (num_obj > pff_pkg::NOBJ_W'(MAX_OBJECTIVES))
        begin
            n_eff = pff_pkg::NOBJ_W'(MAX_OBJECTIVES);
        end
        else
        begin
            n_eff = num_obj;
        end
    end

    always_comb
    begin
        better = 1'b0;
        worse  = 1'b0;
        for (int i = 0; i < MAX_OBJECTIVES; i++)
        begin
            if (i < int'(n_eff))
            begin
                if ($signed(cand_obj[i*OBJ_WIDTH +: OBJ_WIDTH]) <
                    $signed(entry_obj[i*OBJ_WIDTH +: OBJ_WIDTH]))
                begin
                    better = 1'b1;
                end
                else if ($signed(cand_obj[i*OBJ_WIDTH +: OBJ_WIDTH]) >
                         $signed(entry_obj[i*OBJ_WIDTH +: OBJ_WIDTH]))
                begin
                    worse = 1'b1;
                end
            end
        end
    end

    assign cand_inf  = cand_viol[pff_pkg::VIOL_W-1];
    assign entry_inf = entry_viol[pff_pkg::VIOL_W-1];

    always_comb
    begin
        priority if (cand_inf && entry_inf)
        begin
            verdict.cand_wins  = $signed(cand_viol) > $signed(entry_viol);
            verdict.entry_wins = $signed(cand_viol) < $signed(entry_viol);
        end
        else if (cand_inf)
        begin
            verdict.cand_wins  = 1'b0;
            verdict.entry_wins = 1'b1;
        end
        else if (entry_inf)
        begin
            verdict.cand_wins  = 1'b1;
            verdict.entry_wins = 1'b0;
        end
        else
        begin
            verdict.cand_wins  = better && !worse;
            verdict.entry_wins = worse && !better;
        end
    end

endmodule
`default_nettype wire

### rtl/core/pareto_front_filter_top.sv
// Top level of the Pareto front filter: sequencer, entry store and result register.
// Depends on pff_pkg, pff_ram and pff_dom.
//
// A submitted item walks the stored entries once, each with a store read and
// then a compare in the shared dominance unit, and ends with its verdict. The
// walk compacts the store in place: kept entries are rewritten at the write
// pointer, which never passes the read pointer, so evictions need no separate
// shift. A drain returns each stored id in turn; a clear or an empty drain
// gives a single result. Each result waits in one output register; the walk
// pauses while that register is full and stalled. in_stall is high from
// acceptance until the last result is loaded.
`default_nettype none
module pareto_front_filter_top #(
    parameter int CAPACITY       = pff_pkg::CAPACITY_DEF,
    parameter int MAX_OBJECTIVES = pff_pkg::MAX_OBJECTIVES_DEF,
    parameter int OBJ_WIDTH      = pff_pkg::OBJ_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [15:0] candidate_id,
    input  wire logic [15:0] obj_0,
    input  wire logic [15:0] obj_1,
    input  wire logic [15:0] obj_2,
    input  wire logic [15:0] obj_3,
    input  wire logic [15:0] violation,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic [15:0]      entry_id,
    output logic             last
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int OW   = MAX_OBJECTIVES * OBJ_WIDTH;
    localparam int EW   = pff_pkg::ID_W + OW + pff_pkg::VIOL_W;
    localparam int OBJ0 = pff_pkg::ID_W;
    localparam int VIO0 = pff_pkg::ID_W + OW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ONE,
        ST_READ,
        ST_CMP,
        ST_VERDICT
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_reg, rd_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic drain_reg, drain_next;
    logic dominated_reg, dominated_next;
    logic [2:0] one_kind_reg, one_kind_next;
    logic [pff_pkg::NOBJ_W-1:0] nobj_reg;
    logic [EW-1:0] cand_reg, cand_next;
    logic out_valid_reg, out_valid_next;
    logic [2:0] kind_reg, kind_next;
    logic [15:0] id_reg, id_next;
    logic last_reg, last_next;

    logic [15:0] in_obj [4];
    logic [OW-1:0] in_obj_packed;
    logic out_free;
    logic ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;
    pff_pkg::dom_t verdict;

    assign in_obj[0] = obj_0;
    assign in_obj[1] = obj_1;
    assign in_obj[2] = obj_2;
    assign in_obj[3] = obj_3;

    always_comb
    begin
        for (int i = 0; i < MAX_OBJECTIVES; i++)
        begin
            in_obj_packed[i*OBJ_WIDTH +: OBJ_WIDTH] = in_obj[i][OBJ_WIDTH-1:0];
        end
    end

    pff_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    pff_dom #(
        .MAX_OBJECTIVES (MAX_OBJECTIVES),
        .OBJ_WIDTH      (OBJ_WIDTH)
    ) u_dom (
        .cand_obj   (cand_reg[OBJ0 +: OW]),
        .cand_viol  (cand_reg[VIO0 +: pff_pkg::VIOL_W]),
        .entry_obj  (ram_rdata[OBJ0 +: OW]),
        .entry_viol (ram_rdata[VIO0 +: pff_pkg::VIOL_W]),
        .num_obj    (nobj_reg),
        .verdict    (verdict)
    );

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        drain_next     = drain_reg;
        dominated_next = dominated_reg;
        one_kind_next  = one_kind_reg;
        cand_next      = cand_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        id_next        = id_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        ram_waddr      = wr_reg[AW-1:0];
        ram_wdata      = ram_rdata;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cand_next      = {violation, in_obj_packed, candidate_id};
                    rd_next        = '0;
                    wr_next        = '0;
                    dominated_next = 1'b0;
                    priority if (cmd == pff_pkg::CMD_SUBMIT)
                    begin
                        drain_next = 1'b0;
                        state_next = ST_READ;
                    end
                    else if (cmd == pff_pkg::CMD_CLEAR)
                    begin
                        one_kind_next = pff_pkg::KIND_CLEAR;
                        state_next    = ST_ONE;
                    end
                    else if (cmd == pff_pkg::CMD_DRAIN)
                    begin
                        drain_next = 1'b1;
                        if (count_reg == '0)
                        begin
                            one_kind_next = pff_pkg::KIND_EMPTY;
                            state_next    = ST_ONE;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = one_kind_reg;
                    id_next        = '0;
                    last_next      = 1'b1;
                    if (one_kind_reg == pff_pkg::KIND_CLEAR)
                    begin
                        count_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                // The store is read at rd_reg here; the registered data is used in ST_CMP.
                if (rd_reg == count_reg)
                begin
                    state_next = ST_VERDICT;
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (drain_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = pff_pkg::KIND_DRAIN;
                        id_next        = ram_rdata[pff_pkg::ID_W-1:0];
                        last_next      = (rd_reg == count_reg - CW'(1));
                        rd_next        = rd_reg + CW'(1);
                        state_next     = (rd_reg == count_reg - CW'(1)) ? ST_IDLE : ST_READ;
                    end
                end
                else if (!dominated_reg && verdict.cand_wins)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = pff_pkg::KIND_EVICT;
                        id_next        = ram_rdata[pff_pkg::ID_W-1:0];
                        last_next      = 1'b0;
                        rd_next        = rd_reg + CW'(1);
                        state_next     = ST_READ;
                    end
                end
                else
                begin
                    // Kept entry, or the rest of the store after the candidate lost.
                    ram_we  = 1'b1;
                    wr_next = wr_reg + CW'(1);
                    rd_next = rd_reg + CW'(1);
                    if (verdict.entry_wins)
                    begin
                        dominated_next = 1'b1;
                    end
                    state_next = ST_READ;
                end
            end
            ST_VERDICT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    id_next        = cand_reg[pff_pkg::ID_W-1:0];
                    last_next      = 1'b1;
                    count_next     = wr_reg;
                    priority if (dominated_reg)
                    begin
                        kind_next = pff_pkg::KIND_REJECT;
                    end
                    else if (wr_reg == CW'(CAPACITY))
                    begin
                        kind_next = pff_pkg::KIND_FULL;
                    end
                    else
                    begin
                        kind_next  = pff_pkg::KIND_ACCEPT;
                        ram_we     = 1'b1;
                        ram_wdata  = cand_reg;
                        count_next = wr_reg + CW'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            drain_reg     <= 1'b0;
            dominated_reg <= 1'b0;
            one_kind_reg  <= pff_pkg::KIND_CLEAR;
            nobj_reg      <= pff_pkg::NOBJ_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            drain_reg     <= drain_next;
            dominated_reg <= dominated_next;
            one_kind_reg  <= one_kind_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                nobj_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        kind_reg <= kind_next;
        id_reg   <= id_next;
        last_reg <= last_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign entry_id  = id_reg;
    assign last      = last_reg;

endmodule
`default_nettype wire

### rtl/core/pff_checker.sv
// Port-level checker for the Pareto front filter, bound to the top level.
// Depends on pff_pkg and pareto_front_filter_top.
`default_nettype none
module pff_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [1:0]  cmd,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  kind,
    input wire logic [15:0] entry_id,
    input wire logic        last
);

    // A held result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(entry_id)
            && $stable(last))
        else $error("stalled result changed");

    // Any real command keeps the block busy in the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == pff_pkg::CMD_SUBMIT || cmd == pff_pkg::CMD_CLEAR
            || cmd == pff_pkg::CMD_DRAIN) |=> in_stall)
        else $error("item accepted without going busy");

    // Verdicts and single results always close their item.
    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == pff_pkg::KIND_ACCEPT || kind == pff_pkg::KIND_REJECT
            || kind == pff_pkg::KIND_FULL || kind == pff_pkg::KIND_CLEAR
            || kind == pff_pkg::KIND_EMPTY) |-> last)
        else $error("final result without last");

    // An eviction is never the last result of a submit.
    a_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == pff_pkg::KIND_EVICT |-> !last)
        else $error("eviction marked last");

    // Results of unused codes never appear.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind <= pff_pkg::KIND_EMPTY)
        else $error("unknown result kind");

endmodule

bind pareto_front_filter_top pff_checker u_pff_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .entry_id  (entry_id),
    .last      (last)
);
`default_nettype wire
